/* hdl/cgrd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cgrd_pkg
// Shared codes and field widths for the coverage gap range decrement block.
// ----------------------------------------------------------------------------
package cgrd_pkg;

  localparam int unsigned REQ_W    = 3;
  localparam int unsigned ADDR_W   = 16;
  localparam int unsigned WDATA_W  = 17;
  localparam int unsigned POS_W    = 17;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned RDATA_W  = 16;
  localparam int unsigned LOCAL_W  = 13;
  localparam int unsigned CNT_W    = 13;
  localparam int unsigned LEN_W    = 17;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 17;

  localparam logic [REQ_W-1:0] REQ_WR_COV   = 3'd0;
  localparam logic [REQ_W-1:0] REQ_WR_MAP   = 3'd1;
  localparam logic [REQ_W-1:0] REQ_WR_START = 3'd2;
  localparam logic [REQ_W-1:0] REQ_GAP      = 3'd3;
  localparam logic [REQ_W-1:0] REQ_RD_COV   = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_SKIP      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NODE      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_LOCAL     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_RANGE     = 3'd4;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_NODE_MAP_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_ENTRIES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BP_LENGTH     = 2'd2;

endpackage
`default_nettype wire

/* hdl/cgrd_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cgrd_if
// Request, response and configuration channels (valid/ready).
// ----------------------------------------------------------------------------
interface cgrd_req_if;
  logic                             valid;
  logic                             ready;
  logic [cgrd_pkg::REQ_W-1:0]       req_type;
  logic [cgrd_pkg::ADDR_W-1:0]      address;
  logic [cgrd_pkg::WDATA_W-1:0]     wdata;
  logic                             map_excluded;
  logic [cgrd_pkg::POS_W-1:0]       gap_start;
  logic [cgrd_pkg::POS_W-1:0]       gap_end;

  modport source (output valid, req_type, address, wdata, map_excluded, gap_start, gap_end,
                  input ready);
  modport sink   (input valid, req_type, address, wdata, map_excluded, gap_start, gap_end,
                  output ready);
endinterface

interface cgrd_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [cgrd_pkg::STATUS_W-1:0]    status;
  logic [cgrd_pkg::RDATA_W-1:0]     read_data;
  logic [cgrd_pkg::POS_W-1:0]       fault_position;

  modport source (output valid, status, read_data, fault_position, input ready);
  modport sink   (input valid, status, read_data, fault_position, output ready);
endinterface

interface cgrd_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [cgrd_pkg::CFG_IDX_W-1:0]   index;
  logic [cgrd_pkg::CFG_DAT_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* hdl/coverage_gap_range_decrement.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// coverage_gap_range_decrement
// Per-base-pair coverage store with node mapping and gap range decrement.
// ----------------------------------------------------------------------------
// Channels: req_i takes request beats (coverage, node map and start table
// writes, gap applications, coverage reads); rsp_o returns one beat per
// request with status, read data and underflow position; cfg_i writes the
// node map size, start table entry count and base-pair length (always ready).
// Steps per request, accept to the next accept: a write goes straight to the
//   done state, a coverage read passes a read state, and a gap passes the map,
//   base and walk states, the walk visiting each position until one is found
//   at zero (a gap rejected by a check or with an empty range ends early).
// The response beat becomes valid in the same cycle that the next request can be taken.
// A gap walks its range one position per cycle, writing the decremented value
// back to the coverage memory while the registered read of the next position is under way.
// A finished response waits in an output register; the next request is taken
// meanwhile and holds its result until the output register frees up, so a
// stalled receiver stops intake after one request.
// Reset clears the control state and configuration registers; memory
// contents are undefined until written and need no clearing pass.
// ----------------------------------------------------------------------------
module coverage_gap_range_decrement #(
  parameter int unsigned BP_DEPTH   = 65536,
  parameter int unsigned MAP_DEPTH  = 4096,
  parameter int unsigned NODE_DEPTH = 4096,
  parameter int unsigned COV_WIDTH  = 16
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  cgrd_cfg_if.sink   cfg_i,
  cgrd_req_if.sink   req_i,
  cgrd_rsp_if.source rsp_o
);

  localparam int unsigned ST_DEPTH = NODE_DEPTH + 1;
  localparam int unsigned BP_AW    = $clog2(BP_DEPTH);
  localparam int unsigned MAP_AW   = $clog2(MAP_DEPTH);
  localparam int unsigned ST_AW    = $clog2(ST_DEPTH);
  localparam int unsigned MAP_DW   = cgrd_pkg::LOCAL_W + 1;
  localparam int unsigned POS_W_T  = cgrd_pkg::POS_W;
  localparam logic [31:0] BP_LIM   = 32'(BP_DEPTH);
  localparam logic [31:0] MAP_LIM  = 32'(MAP_DEPTH);
  localparam logic [31:0] NODE_LIM = 32'(NODE_DEPTH);
  localparam logic [31:0] ST_LIM   = 32'(ST_DEPTH);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_RD   = 6'b000010,
    S_MAP  = 6'b000100,
    S_BASE = 6'b001000,
    S_WALK = 6'b010000,
    S_DONE = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [cgrd_pkg::CNT_W-1:0] node_map_size_q;
  logic [cgrd_pkg::CNT_W-1:0] start_entries_q;
  logic [cgrd_pkg::LEN_W-1:0] bp_length_q;

  logic [cgrd_pkg::POS_W-1:0]    gs_q, gs_d, ge_q, ge_d;
  logic [cgrd_pkg::POS_W-1:0]    pos_q, pos_d, end_q, end_d;
  logic [cgrd_pkg::STATUS_W-1:0] res_status_q, res_status_d;
  logic [cgrd_pkg::RDATA_W-1:0]  res_rdata_q, res_rdata_d;
  logic [cgrd_pkg::POS_W-1:0]    res_fault_q, res_fault_d;

  logic                          out_valid_q, out_valid_d;
  logic [cgrd_pkg::STATUS_W-1:0] out_status_q, out_status_d;
  logic [cgrd_pkg::RDATA_W-1:0]  out_rdata_q, out_rdata_d;
  logic [cgrd_pkg::POS_W-1:0]    out_fault_q, out_fault_d;

  logic [COV_WIDTH-1:0] cov_mem [BP_DEPTH];
  logic [MAP_DW-1:0]    map_mem [MAP_DEPTH];
  logic [POS_W_T-1:0]   st_mem  [ST_DEPTH];

  logic                 cov_we, cov_re;
  logic [BP_AW-1:0]     cov_waddr, cov_raddr;
  logic [COV_WIDTH-1:0] cov_wdata, cov_rdata_q;
  logic                 map_we, map_re;
  logic [MAP_AW-1:0]    map_waddr, map_raddr;
  logic [MAP_DW-1:0]    map_wdata, map_rdata_q;
  logic                 st_we, st_re;
  logic [ST_AW-1:0]     st_waddr, st_raddr;
  logic [POS_W_T-1:0]   st_wdata, st_rdata_q;

  logic                          req_accept;
  logic [31:0]                   addr_ext;
  logic [32:0]                   wdata_ext;
  logic                          cov_sat;
  logic [COV_WIDTH-1:0]          cov_wval;
  logic [cgrd_pkg::LOCAL_W-1:0]  node_local;
  logic                          local_bad;
  logic [cgrd_pkg::POS_W:0]      from_pos, to_pos;
  logic [cgrd_pkg::POS_W-1:0]    pos_nxt;

  assign cfg_i.ready = 1'b1;
  assign req_i.ready = (state_q == S_IDLE);
  assign req_accept  = req_i.valid && req_i.ready;

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.status         = out_status_q;
  assign rsp_o.read_data      = out_rdata_q;
  assign rsp_o.fault_position = out_fault_q;

  assign addr_ext  = 32'(req_i.address);
  assign wdata_ext = 33'(req_i.wdata);
  assign cov_sat   = (wdata_ext >> COV_WIDTH) != '0;
  assign cov_wval  = cov_sat ? '1 : COV_WIDTH'(req_i.wdata);

  assign node_local = map_rdata_q[cgrd_pkg::LOCAL_W-1:0];
  assign local_bad  = ((14'(node_local) + 14'd1) >= 14'(start_entries_q))
                   || (32'(node_local) >= NODE_LIM);

  assign from_pos = 18'(st_rdata_q) + 18'(gs_q);
  assign to_pos   = 18'(st_rdata_q) + 18'(ge_q);
  assign pos_nxt  = pos_q + 17'd1;

  always_comb begin
    state_d      = state_q;
    gs_d         = gs_q;
    ge_d         = ge_q;
    pos_d        = pos_q;
    end_d        = end_q;
    res_status_d = res_status_q;
    res_rdata_d  = res_rdata_q;
    res_fault_d  = res_fault_q;
    out_valid_d  = out_valid_q && !rsp_o.ready;
    out_status_d = out_status_q;
    out_rdata_d  = out_rdata_q;
    out_fault_d  = out_fault_q;
    cov_we    = 1'b0;
    cov_waddr = '0;
    cov_wdata = '0;
    cov_re    = 1'b0;
    cov_raddr = '0;
    map_we    = 1'b0;
    map_waddr = '0;
    map_wdata = '0;
    map_re    = 1'b0;
    map_raddr = '0;
    st_we     = 1'b0;
    st_waddr  = '0;
    st_wdata  = '0;
    st_re     = 1'b0;
    st_raddr  = '0;

    unique case (state_q)
      S_IDLE: begin
        if (req_accept) begin
          gs_d         = req_i.gap_start;
          ge_d         = req_i.gap_end;
          res_status_d = cgrd_pkg::ST_OK;
          res_rdata_d  = '0;
          res_fault_d  = '0;
          state_d      = S_DONE;
          unique case (req_i.req_type)
            cgrd_pkg::REQ_WR_COV: begin
              if (addr_ext < BP_LIM) begin
                cov_we    = 1'b1;
                cov_waddr = BP_AW'(req_i.address);
                cov_wdata = cov_wval;
              end else begin
                res_status_d = cgrd_pkg::ST_RANGE;
              end
            end
            cgrd_pkg::REQ_WR_MAP: begin
              if (addr_ext < MAP_LIM) begin
                map_we    = 1'b1;
                map_waddr = MAP_AW'(req_i.address);
                map_wdata = {req_i.map_excluded, req_i.wdata[cgrd_pkg::LOCAL_W-1:0]};
              end else begin
                res_status_d = cgrd_pkg::ST_NODE;
              end
            end
            cgrd_pkg::REQ_WR_START: begin
              if (addr_ext < ST_LIM) begin
                st_we    = 1'b1;
                st_waddr = ST_AW'(req_i.address);
                st_wdata = req_i.wdata;
              end else begin
                res_status_d = cgrd_pkg::ST_LOCAL;
              end
            end
            cgrd_pkg::REQ_GAP: begin
              if ((req_i.address < 16'(node_map_size_q)) && (addr_ext < MAP_LIM)) begin
                map_re    = 1'b1;
                map_raddr = MAP_AW'(req_i.address);
                state_d   = S_MAP;
              end else begin
                res_status_d = cgrd_pkg::ST_NODE;
              end
            end
            cgrd_pkg::REQ_RD_COV: begin
              if (addr_ext < BP_LIM) begin
                cov_re    = 1'b1;
                cov_raddr = BP_AW'(req_i.address);
                state_d   = S_RD;
              end else begin
                res_status_d = cgrd_pkg::ST_RANGE;
              end
            end
            default: ;
          endcase
        end
      end
      S_RD: begin
        res_rdata_d = cgrd_pkg::RDATA_W'(cov_rdata_q);
        state_d     = S_DONE;
      end
      S_MAP: begin
        if (map_rdata_q[cgrd_pkg::LOCAL_W]) begin
          res_status_d = cgrd_pkg::ST_SKIP;
          state_d      = S_DONE;
        end else if (local_bad) begin
          res_status_d = cgrd_pkg::ST_LOCAL;
          state_d      = S_DONE;
        end else begin
          st_re    = 1'b1;
          st_raddr = ST_AW'(node_local);
          state_d  = S_BASE;
        end
      end
      S_BASE: begin
        if (from_pos >= to_pos) begin
          state_d = S_DONE;
        end else if ((to_pos > 18'(bp_length_q)) || (32'(to_pos) > BP_LIM)) begin
          res_status_d = cgrd_pkg::ST_RANGE;
          state_d      = S_DONE;
        end else begin
          pos_d     = from_pos[cgrd_pkg::POS_W-1:0];
          end_d     = to_pos[cgrd_pkg::POS_W-1:0];
          cov_re    = 1'b1;
          cov_raddr = BP_AW'(from_pos);
          state_d   = S_WALK;
        end
      end
      S_WALK: begin
        if (cov_rdata_q == '0) begin
          res_status_d = cgrd_pkg::ST_UNDERFLOW;
          res_fault_d  = pos_q;
          state_d      = S_DONE;
        end else begin
          cov_we    = 1'b1;
          cov_waddr = BP_AW'(pos_q);
          cov_wdata = cov_rdata_q - COV_WIDTH'(1);
          if (pos_nxt == end_q) begin
            state_d = S_DONE;
          end else begin
            cov_re    = 1'b1;
            cov_raddr = BP_AW'(pos_nxt);
            pos_d     = pos_nxt;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_rdata_d  = res_rdata_q;
          out_fault_d  = res_fault_q;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_IDLE;
      out_valid_q     <= 1'b0;
      node_map_size_q <= '0;
      start_entries_q <= '0;
      bp_length_q     <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_i.valid && cfg_i.ready) begin
        unique case (cfg_i.index)
          cgrd_pkg::CFG_NODE_MAP_SIZE: node_map_size_q <= cfg_i.data[cgrd_pkg::CNT_W-1:0];
          cgrd_pkg::CFG_START_ENTRIES: start_entries_q <= cfg_i.data[cgrd_pkg::CNT_W-1:0];
          cgrd_pkg::CFG_BP_LENGTH:     bp_length_q     <= cfg_i.data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    gs_q         <= gs_d;
    ge_q         <= ge_d;
    pos_q        <= pos_d;
    end_q        <= end_d;
    res_status_q <= res_status_d;
    res_rdata_q  <= res_rdata_d;
    res_fault_q  <= res_fault_d;
    out_status_q <= out_status_d;
    out_rdata_q  <= out_rdata_d;
    out_fault_q  <= out_fault_d;
  end

  always_ff @(posedge clk_i) begin
    if (cov_we) begin
      cov_mem[cov_waddr] <= cov_wdata;
    end
    if (cov_re) begin
      cov_rdata_q <= cov_mem[cov_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (map_we) begin
      map_mem[map_waddr] <= map_wdata;
    end
    if (map_re) begin
      map_rdata_q <= map_mem[map_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_we) begin
      st_mem[st_waddr] <= st_wdata;
    end
    if (st_re) begin
      st_rdata_q <= st_mem[st_raddr];
    end
  end

endmodule
`default_nettype wire

/* hdl/cgrd_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cgrd_checker
// Port-level checks on the response channel, bound to the top level.
// ----------------------------------------------------------------------------
module cgrd_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          rsp_valid_i,
  input wire logic                          rsp_ready_i,
  input wire logic [cgrd_pkg::STATUS_W-1:0] status_i,
  input wire logic [cgrd_pkg::RDATA_W-1:0]  read_data_i,
  input wire logic [cgrd_pkg::POS_W-1:0]    fault_position_i
);

  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("response beat dropped while stalled");

  a_payload_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> $stable(status_i) && $stable(read_data_i)
                                    && $stable(fault_position_i))
    else $error("response payload changed while stalled");

  a_fault_only_on_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (fault_position_i != '0) |-> status_i == cgrd_pkg::ST_UNDERFLOW)
    else $error("fault position without underflow status");

  a_read_data_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (read_data_i != '0) |-> status_i == cgrd_pkg::ST_OK)
    else $error("read data with error status");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> status_i <= cgrd_pkg::ST_UNDERFLOW)
    else $error("status code out of range");

endmodule

bind coverage_gap_range_decrement cgrd_checker u_cgrd_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .rsp_valid_i      (rsp_o.valid),
  .rsp_ready_i      (rsp_o.ready),
  .status_i         (rsp_o.status),
  .read_data_i      (rsp_o.read_data),
  .fault_position_i (rsp_o.fault_position)
);
`default_nettype wire

/* dv/coverage_gap_range_decrement_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coverage_gap_range_decrement_test
// Self-checking bench for the coverage gap range decrement block. A directed
// table covers saturation, the store edges and every status code. Random
// load / gap / read sequences follow under several register settings.
// Each beat on rsp_o is compared with an in-order prediction.
// ----------------------------------------------------------------------------
module coverage_gap_range_decrement_test;

  localparam int unsigned BP_DEPTH     = 65536;
  localparam int unsigned MAP_DEPTH    = 4096;
  localparam int unsigned NODE_DEPTH   = 4096;
  localparam int unsigned COV_WIDTH    = 16;
  localparam int unsigned COV_MAX      = (1 << COV_WIDTH) - 1;
  localparam int unsigned LONG_HOLD    = 400;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam longint      TIMEOUT_NS   = 64'd12_000_000;

  localparam logic [cgrd_pkg::REQ_W-1:0] REQ_UNUSED = 3'd7;

  typedef struct packed {
    logic [cgrd_pkg::REQ_W-1:0]   kind;
    logic [cgrd_pkg::ADDR_W-1:0]  addr;
    logic [cgrd_pkg::WDATA_W-1:0] wdata;
    logic                         excl;
    logic [cgrd_pkg::POS_W-1:0]   gap_start;
    logic [cgrd_pkg::POS_W-1:0]   gap_end;
  } cov_req_t;

  typedef struct packed {
    logic [cgrd_pkg::STATUS_W-1:0] status;
    logic [cgrd_pkg::RDATA_W-1:0]  read_data;
    logic [cgrd_pkg::POS_W-1:0]    fault_pos;
  } cov_rsp_t;

  typedef struct packed {
    cov_req_t req;
    logic     fixed;
    cov_rsp_t rsp;
  } directed_row_t;

  // request, typed-in flag, typed-in response
  directed_row_t directed_rows [$] = '{
    '{'{cgrd_pkg::REQ_WR_COV,   0,     65536, 0, 0, 0}, 1, '{cgrd_pkg::ST_OK, 0, 0}},
    '{'{cgrd_pkg::REQ_RD_COV,   0,     0,     0, 0, 0}, 1, '{cgrd_pkg::ST_OK, 65535, 0}},
    '{'{cgrd_pkg::REQ_WR_COV,   65535, 1,     0, 0, 0}, 1, '{cgrd_pkg::ST_OK, 0, 0}},
    '{'{cgrd_pkg::REQ_RD_COV,   65535, 0,     0, 0, 0}, 1, '{cgrd_pkg::ST_OK, 1, 0}},
    '{'{cgrd_pkg::REQ_WR_COV,   1,     0,     0, 0, 0}, 1, '{cgrd_pkg::ST_OK, 0, 0}},
    '{'{cgrd_pkg::REQ_WR_MAP,   0,     0,     0, 0, 0}, 1, '{cgrd_pkg::ST_OK, 0, 0}},
    '{'{cgrd_pkg::REQ_WR_START, 0,     0,     0, 0, 0}, 1, '{cgrd_pkg::ST_OK, 0, 0}},
    '{'{cgrd_pkg::REQ_GAP,      0,     0,     0, 0, 2}, 1, '{cgrd_pkg::ST_UNDERFLOW, 0, 1}},
    '{'{cgrd_pkg::REQ_RD_COV,   0,     0,     0, 0, 0}, 1, '{cgrd_pkg::ST_OK, 65534, 0}},
    '{'{cgrd_pkg::REQ_WR_MAP,   4095,  4095,  0, 0, 0}, 1, '{cgrd_pkg::ST_OK, 0, 0}},
    '{'{cgrd_pkg::REQ_WR_START, 4095,  65535, 0, 0, 0}, 1, '{cgrd_pkg::ST_OK, 0, 0}},
    '{'{cgrd_pkg::REQ_GAP,      4095,  0,     0, 0, 1}, 1, '{cgrd_pkg::ST_OK, 0, 0}},
    '{'{cgrd_pkg::REQ_GAP,      4095,  0,     0, 0, 1}, 1,
      '{cgrd_pkg::ST_UNDERFLOW, 0, 65535}},
    '{'{cgrd_pkg::REQ_GAP,      4095,  0,     0, 0, 2}, 1, '{cgrd_pkg::ST_RANGE, 0, 0}},
    '{'{cgrd_pkg::REQ_GAP,      4095,  0,     0, 65536, 0}, 1, '{cgrd_pkg::ST_OK, 0, 0}},
    '{'{cgrd_pkg::REQ_WR_MAP,   4096,  0,     0, 0, 0}, 1, '{cgrd_pkg::ST_NODE, 0, 0}},
    '{'{cgrd_pkg::REQ_WR_START, 4096,  65536, 0, 0, 0}, 1, '{cgrd_pkg::ST_OK, 0, 0}},
    '{'{cgrd_pkg::REQ_WR_START, 4097,  0,     0, 0, 0}, 1, '{cgrd_pkg::ST_LOCAL, 0, 0}},
    '{'{cgrd_pkg::REQ_WR_MAP,   1,     8191,  1, 0, 0}, 1, '{cgrd_pkg::ST_OK, 0, 0}},
    '{'{cgrd_pkg::REQ_GAP,      1,     0,     0, 0, 1}, 1, '{cgrd_pkg::ST_SKIP, 0, 0}},
    '{'{cgrd_pkg::REQ_WR_MAP,   2,     4096,  0, 0, 0}, 1, '{cgrd_pkg::ST_OK, 0, 0}},
    '{'{cgrd_pkg::REQ_GAP,      2,     0,     0, 0, 1}, 1, '{cgrd_pkg::ST_LOCAL, 0, 0}},
    '{'{cgrd_pkg::REQ_WR_MAP,   3,     8191,  0, 0, 0}, 1, '{cgrd_pkg::ST_OK, 0, 0}},
    '{'{cgrd_pkg::REQ_GAP,      3,     0,     0, 0, 1}, 1, '{cgrd_pkg::ST_LOCAL, 0, 0}},
    '{'{cgrd_pkg::REQ_GAP,      65535, 0,     0, 0, 1}, 1, '{cgrd_pkg::ST_NODE, 0, 0}},
    '{'{REQ_UNUSED,   65535, 65536, 1, 65536, 65536}, 1, '{cgrd_pkg::ST_OK, 0, 0}},
    '{'{cgrd_pkg::REQ_GAP,      0,     0,     0, 0, 3}, 0, '{cgrd_pkg::ST_OK, 0, 0}},
    '{'{cgrd_pkg::REQ_RD_COV,   0,     0,     0, 0, 0}, 0, '{cgrd_pkg::ST_OK, 0, 0}}
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  cgrd_cfg_if cfg_if ();
  cgrd_req_if req_if ();
  cgrd_rsp_if rsp_if ();

  coverage_gap_range_decrement #(
    .BP_DEPTH  (BP_DEPTH),
    .MAP_DEPTH (MAP_DEPTH),
    .NODE_DEPTH(NODE_DEPTH),
    .COV_WIDTH (COV_WIDTH)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_if),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // shadow of the block's memories and registers
  logic [COV_WIDTH-1:0]         cov_mem   [BP_DEPTH];
  bit                           cov_wr    [BP_DEPTH];
  int unsigned                  cov_written_q [$];
  logic [cgrd_pkg::LOCAL_W-1:0] map_local [MAP_DEPTH];
  bit                           map_excl  [MAP_DEPTH];
  bit                           map_wr    [MAP_DEPTH];
  logic [cgrd_pkg::WDATA_W-1:0] start_pos [NODE_DEPTH+1];
  bit                           start_wr  [NODE_DEPTH+1];
  int unsigned                  cfg_map_size, cfg_start_entries, cfg_bp_len;

  cov_rsp_t    coverage_rsp_pending [$];
  int unsigned mismatches;
  int unsigned items_sent;
  int unsigned tx_idle_max;
  int unsigned rx_idle_max;
  int unsigned rx_hold_cycles;

  function automatic cov_rsp_t apply_coverage_request(cov_req_t r);
    cov_rsp_t    res;
    int unsigned lcl, base, from, to, pos;
    bit          walking;
    res = '0;
    case (r.kind)
      cgrd_pkg::REQ_WR_COV: begin
        if (r.addr >= BP_DEPTH) begin
          res.status = cgrd_pkg::ST_RANGE;
        end else begin
          if (!cov_wr[r.addr]) cov_written_q = {cov_written_q, 32'(r.addr)};
          cov_wr[r.addr]  = 1'b1;
          cov_mem[r.addr] = (r.wdata > COV_MAX) ? COV_WIDTH'(COV_MAX) : r.wdata[COV_WIDTH-1:0];
        end
      end
      cgrd_pkg::REQ_WR_MAP: begin
        if (r.addr >= MAP_DEPTH) begin
          res.status = cgrd_pkg::ST_NODE;
        end else begin
          map_local[r.addr] = r.wdata[cgrd_pkg::LOCAL_W-1:0];
          map_excl[r.addr]  = r.excl;
          map_wr[r.addr]    = 1'b1;
        end
      end
      cgrd_pkg::REQ_WR_START: begin
        if (r.addr >= NODE_DEPTH + 1) begin
          res.status = cgrd_pkg::ST_LOCAL;
        end else begin
          start_pos[r.addr] = r.wdata;
          start_wr[r.addr]  = 1'b1;
        end
      end
      cgrd_pkg::REQ_RD_COV: begin
        if (r.addr >= BP_DEPTH) res.status = cgrd_pkg::ST_RANGE;
        else res.read_data = cov_mem[r.addr];
      end
      cgrd_pkg::REQ_GAP: begin
        if (r.addr >= cfg_map_size || r.addr >= MAP_DEPTH) begin
          res.status = cgrd_pkg::ST_NODE;
        end else if (map_excl[r.addr]) begin
          res.status = cgrd_pkg::ST_SKIP;
        end else begin
          lcl = 32'(map_local[r.addr]);
          if (lcl + 1 >= cfg_start_entries || lcl >= NODE_DEPTH) begin
            res.status = cgrd_pkg::ST_LOCAL;
          end else begin
            base = 32'(start_pos[lcl]);
            from = base + 32'(r.gap_start);
            to   = base + 32'(r.gap_end);
            if (from < to) begin
              if (to > cfg_bp_len || to > BP_DEPTH) begin
                res.status = cgrd_pkg::ST_RANGE;
              end else begin
                pos     = from;
                walking = 1'b1;
                while (walking && pos < to) begin
                  if (cov_mem[pos] == '0) begin
                    res.status    = cgrd_pkg::ST_UNDERFLOW;
                    res.fault_pos = cgrd_pkg::POS_W'(pos);
                    walking       = 1'b0;
                  end else begin
                    cov_mem[pos] = cov_mem[pos] - 1'b1;
                    pos++;
                  end
                end
              end
            end
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // memories are undefined until written: never let a request read such an entry
  function automatic bit reads_are_defined(cov_req_t r);
    int unsigned lcl, from, to, p;
    case (r.kind)
      cgrd_pkg::REQ_RD_COV: return (r.addr >= BP_DEPTH) || cov_wr[r.addr];
      cgrd_pkg::REQ_GAP: begin
        if (r.addr >= cfg_map_size || r.addr >= MAP_DEPTH) return 1'b1;
        if (!map_wr[r.addr]) return 1'b0;
        if (map_excl[r.addr]) return 1'b1;
        lcl = 32'(map_local[r.addr]);
        if (lcl + 1 >= cfg_start_entries || lcl >= NODE_DEPTH) return 1'b1;
        if (!start_wr[lcl]) return 1'b0;
        from = 32'(start_pos[lcl]) + 32'(r.gap_start);
        to   = 32'(start_pos[lcl]) + 32'(r.gap_end);
        if (from >= to || to > cfg_bp_len || to > BP_DEPTH) return 1'b1;
        for (p = from; p < to; p++) begin
          if (!cov_wr[p]) return 1'b0;
          if (cov_mem[p] == '0) return 1'b1;
        end
        return 1'b1;
      end
      default: return 1'b1;
    endcase
  endfunction

  function automatic int unsigned pick_wide();
    case ($urandom_range(0, 3))
      0:       return $urandom_range(0, 15);
      1:       return $urandom_range(0, 65535);
      2:       return 65536;
      default: return $urandom_range(0, 4096);
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t mismatch %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  task automatic wait_drain();
    while (coverage_rsp_pending.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_config(int unsigned map_size, int unsigned start_entries,
                            int unsigned bp_len);
    logic [cgrd_pkg::CFG_IDX_W-1:0] idx [3];
    int unsigned                    val [3];
    int                             i;
    idx = '{cgrd_pkg::CFG_NODE_MAP_SIZE, cgrd_pkg::CFG_START_ENTRIES,
            cgrd_pkg::CFG_BP_LENGTH};
    val = '{map_size, start_entries, bp_len};
    for (i = 0; i < 3; i++) begin
      cfg_if.valid <= 1'b1;
      cfg_if.index <= idx[i];
      cfg_if.data  <= cgrd_pkg::CFG_DAT_W'(val[i]);
      do @(posedge clk_i); while (!cfg_if.ready);
    end
    cfg_if.valid      <= 1'b0;
    cfg_map_size      = map_size % (1 << cgrd_pkg::CNT_W);
    cfg_start_entries = start_entries % (1 << cgrd_pkg::CNT_W);
    cfg_bp_len        = bp_len % (1 << cgrd_pkg::LEN_W);
  endtask

  task automatic send_request(cov_req_t r, bit fixed, cov_rsp_t fixed_rsp);
    int unsigned pause;
    cov_rsp_t    predicted;
    pause = $urandom_range(0, tx_idle_max);
    if (pause > 0) begin
      req_if.valid <= 1'b0;
      repeat (pause) @(posedge clk_i);
    end
    req_if.valid        <= 1'b1;
    req_if.req_type     <= r.kind;
    req_if.address      <= r.addr;
    req_if.wdata        <= r.wdata;
    req_if.map_excluded <= r.excl;
    req_if.gap_start    <= r.gap_start;
    req_if.gap_end      <= r.gap_end;
    do @(posedge clk_i); while (!req_if.ready);
    predicted = apply_coverage_request(r);
    coverage_rsp_pending = {coverage_rsp_pending, fixed ? fixed_rsp : predicted};
    items_sent++;
  endtask

  task automatic send_random(cov_req_t r);
    if (!reads_are_defined(r)) begin
      r      = '0;
      r.kind = cgrd_pkg::REQ_RD_COV;
      r.addr = 16'(cov_written_q[$urandom_range(0, cov_written_q.size() - 1)]);
    end
    send_request(r, 1'b0, '0);
  endtask

  task automatic send_noise();
    cov_req_t r;
    r.kind      = 3'($urandom_range(0, 7));
    r.addr      = 16'($urandom_range(0, 1) ? $urandom_range(0, 65535)
                                            : $urandom_range(0, 4100));
    r.wdata     = 17'(pick_wide());
    r.excl      = 1'($urandom_range(0, 1));
    r.gap_start = 17'(pick_wide());
    r.gap_end   = 17'(pick_wide());
    send_random(r);
  endtask

  // load a range, map a node onto it, apply gaps, read back
  task automatic run_gap_sequence();
    int unsigned node, lcl, lim, len, gs, span, base, p, n;
    bit          reuse;
    cov_req_t    r;
    lim  = (cfg_map_size < MAP_DEPTH) ? cfg_map_size : MAP_DEPTH;
    node = (lim > 0) ? $urandom_range(0, lim - 1) : $urandom_range(0, MAP_DEPTH - 1);
    lim  = (cfg_start_entries >= 2) ? cfg_start_entries - 2 : NODE_DEPTH - 1;
    if (lim > NODE_DEPTH - 1) lim = NODE_DEPTH - 1;
    lcl  = $urandom_range(0, lim);
    len  = ($urandom_range(0, 15) == 0) ? $urandom_range(17, 96) : $urandom_range(1, 16);
    gs   = $urandom_range(0, 3);
    span = gs + len;
    if (cfg_bp_len >= span && $urandom_range(0, 9) != 0) begin
      lim = cfg_bp_len - span;
      if (lim > 4095 && $urandom_range(0, 3) != 0) lim = 4095;
      base = $urandom_range(0, lim);
    end else begin
      base = $urandom_range(0, BP_DEPTH - 1);
    end

    reuse = 1'b1;
    for (p = base + gs; p < base + span && p < BP_DEPTH; p++)
      if (!cov_wr[p]) reuse = 1'b0;
    if (!reuse || $urandom_range(0, 2) != 0) begin
      for (p = base + gs; p < base + span && p < BP_DEPTH; p++) begin
        r       = '0;
        r.kind  = cgrd_pkg::REQ_WR_COV;
        r.addr  = 16'(p);
        r.wdata = 17'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 65536)
                                                  : $urandom_range(0, 3));
        send_random(r);
      end
    end

    r       = '0;
    r.kind  = cgrd_pkg::REQ_WR_MAP;
    r.addr  = 16'(node);
    r.wdata = 17'(lcl);
    r.excl  = ($urandom_range(0, 11) == 0);
    send_random(r);
    r       = '0;
    r.kind  = cgrd_pkg::REQ_WR_START;
    r.addr  = 16'(lcl);
    r.wdata = 17'(base);
    send_random(r);

    n = $urandom_range(1, 2);
    repeat (n) begin
      r           = '0;
      r.kind      = cgrd_pkg::REQ_GAP;
      r.addr      = 16'(node);
      r.gap_start = 17'(gs);
      r.gap_end   = 17'(span);
      send_random(r);
    end

    n = $urandom_range(0, 3);
    repeat (n) begin
      r      = '0;
      r.kind = cgrd_pkg::REQ_RD_COV;
      r.addr = 16'(base + $urandom_range(gs, span - 1));
      send_random(r);
    end
  endtask

  task automatic run_phase(int unsigned n_items, int unsigned map_size,
                           int unsigned start_entries, int unsigned bp_len);
    int unsigned stop;
    req_if.valid <= 1'b0;
    wait_drain();
    set_config(map_size, start_entries, bp_len);
    stop = items_sent + n_items;
    while (items_sent < stop) begin
      if ($urandom_range(0, 30) == 0) begin
        tx_idle_max = ($urandom_range(0, 2) == 0) ? 0 : 8;
        rx_idle_max = ($urandom_range(0, 2) == 0) ? 0 : 8;
      end
      if ($urandom_range(0, 9) < 7) run_gap_sequence();
      else send_noise();
    end
  endtask

  initial begin
    rst_ni              <= 1'b0;
    cfg_if.valid        <= 1'b0;
    cfg_if.index        <= cgrd_pkg::CFG_NODE_MAP_SIZE;
    cfg_if.data         <= '0;
    req_if.valid        <= 1'b0;
    req_if.req_type     <= cgrd_pkg::REQ_WR_COV;
    req_if.address      <= '0;
    req_if.wdata        <= '0;
    req_if.map_excluded <= 1'b0;
    req_if.gap_start    <= '0;
    req_if.gap_end      <= '0;
    tx_idle_max         = 8;
    rx_idle_max         = 8;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_config(MAP_DEPTH, NODE_DEPTH + 1, BP_DEPTH);
    foreach (directed_rows[i])
      send_request(directed_rows[i].req, directed_rows[i].fixed, directed_rows[i].rsp);

    run_phase(250, MAP_DEPTH, NODE_DEPTH + 1, BP_DEPTH);
    rx_hold_cycles = LONG_HOLD;
    run_phase(350, MAP_DEPTH, NODE_DEPTH + 1, BP_DEPTH);
    run_phase(60, 0, 0, 0);
    run_phase(60, MAP_DEPTH, NODE_DEPTH + 1, 0);
    run_phase(400, $urandom_range(16, MAP_DEPTH), $urandom_range(16, NODE_DEPTH + 1),
              $urandom_range(256, BP_DEPTH));
    run_phase(300, $urandom_range(16, MAP_DEPTH), $urandom_range(16, NODE_DEPTH + 1),
              $urandom_range(256, BP_DEPTH));
    run_phase(200, MAP_DEPTH, NODE_DEPTH + 1, BP_DEPTH);

    req_if.valid <= 1'b0;
    wait_drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin : rsp_checker
    int unsigned pause;
    cov_rsp_t    want;
    rsp_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (rx_hold_cycles > 0) begin
        pause          = rx_hold_cycles;
        rx_hold_cycles = 0;
      end else begin
        pause = $urandom_range(0, rx_idle_max);
      end
      if (pause > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (pause) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk_i); while (rsp_if.valid !== 1'b1);
      if (coverage_rsp_pending.size() == 0) begin
        report_mismatch("beat with nothing pending, status", 32'(rsp_if.status), 32'd0);
      end else begin
        want = coverage_rsp_pending.pop_front();
        if (rsp_if.status !== want.status)
          report_mismatch("status", 32'(rsp_if.status), 32'(want.status));
        if (rsp_if.read_data !== want.read_data)
          report_mismatch("read_data", 32'(rsp_if.read_data), 32'(want.read_data));
        if (rsp_if.fault_position !== want.fault_pos)
          report_mismatch("fault_position", 32'(rsp_if.fault_position),
                          32'(want.fault_pos));
      end
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Some tests failed");
    $finish;
  end

endmodule
